// ===== sv/apsw_pkg.sv =====
// ----------------------------------------------------------------------------
// apsw_pkg: shared types and constants for the pixel alpha swizzle unit
// Holds the per-lane pipeline payload, the restoring division step and the
// byte constants used by the premultiply and unpremultiply paths.
// ----------------------------------------------------------------------------
package apsw_pkg;

	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned PROD_W    = 2 * CHAN_W;
	localparam int unsigned NUM_LANES = 3;
	localparam int unsigned DIV_BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES = CHAN_W / DIV_BITS_PER_STAGE;

	localparam logic [CHAN_W-1:0] ALPHA_ZERO   = 8'd0;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
	localparam logic [PROD_W-1:0] PREMUL_BIAS  = 16'd254;

	// configuration register indexes
	localparam logic REG_DIRECTION  = 1'b0;
	localparam logic REG_ALPHA_MODE = 1'b1;

	// direction codes
	localparam logic DIR_READ_OUT = 1'b0;
	localparam logic DIR_WRITE_IN = 1'b1;

	// alpha mode codes
	localparam logic MODE_PREMULT = 1'b0;
	localparam logic MODE_UNMULT  = 1'b1;

	// division state of one lane: partial remainder, dividend bits still to
	// shift in (msb first) and quotient bits gathered so far
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [CHAN_W-1:0] lo;
		logic [CHAN_W-1:0] quo;
	} apsw_div_t;

	// one colour lane as it travels down the pipeline
	typedef struct packed {
		logic              use_div;
		logic              clamp;
		logic [CHAN_W-1:0] byp;
		apsw_div_t         dv;
	} apsw_lane_t;

	// payload of one item past the front end
	typedef struct packed {
		logic [CHAN_W-1:0]            alpha;
		apsw_lane_t [NUM_LANES-1:0]   lane;
	} apsw_item_t;

	// one restoring division step: shift in one dividend bit, subtract the
	// divisor when it fits; returns {quotient bit, new remainder}
	function automatic logic [CHAN_W:0] div_step(
		input logic [CHAN_W-1:0] rem,
		input logic              nbit,
		input logic [CHAN_W-1:0] dvsr
	);
		logic [CHAN_W:0] t;
		logic [CHAN_W:0] d;
		t = {rem, nbit};
		d = {1'b0, dvsr};
		if (t >= d) begin
			div_step = {1'b1, t[CHAN_W-1:0] - dvsr};
		end else begin
			div_step = {1'b0, t[CHAN_W-1:0]};
		end
	endfunction

endpackage

// ===== sv/pixel_alpha_premultiply_swizzle_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_alpha_premultiply_swizzle_unit: BGRA/RGBA swizzle with premultiply
// on write-in and saturating unpremultiply on read-out
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low.
// Depth is set by the restoring divider, two quotient bits per stage over
// four stages, after two front stages for products and setup.
// Reset clears both configuration registers and all pipeline valid bits.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pixel_alpha_premultiply_swizzle_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic                         cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_0,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_1,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_2,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_alpha,
	output logic                         done,
	output logic [apsw_pkg::CHAN_W-1:0]  out_chan_0,
	output logic [apsw_pkg::CHAN_W-1:0]  out_chan_1,
	output logic [apsw_pkg::CHAN_W-1:0]  out_chan_2,
	output logic [apsw_pkg::CHAN_W-1:0]  out_alpha,
	output logic                         clamped
);

	logic                 direction_q;
	logic                 alpha_mode_q;

	logic                 vld_pipe  [apsw_pkg::DIV_STAGES+1];
	apsw_pkg::apsw_item_t item_pipe [apsw_pkg::DIV_STAGES+1];

	logic [apsw_pkg::CHAN_W-1:0] res [apsw_pkg::NUM_LANES];
	apsw_pkg::apsw_item_t        last;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= apsw_pkg::DIR_READ_OUT;
			alpha_mode_q <= apsw_pkg::MODE_PREMULT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				apsw_pkg::REG_DIRECTION:  direction_q  <= cfg_data;
				apsw_pkg::REG_ALPHA_MODE: alpha_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	apsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (start && !busy),
		.in_chan_0  (in_chan_0),
		.in_chan_1  (in_chan_1),
		.in_chan_2  (in_chan_2),
		.in_alpha   (in_alpha),
		.direction  (direction_q),
		.alpha_mode (alpha_mode_q),
		.out_vld    (vld_pipe[0]),
		.out_item   (item_pipe[0])
	);

	// divider stages, two quotient bits each
	for (genvar g = 0; g < apsw_pkg::DIV_STAGES; g++) begin : g_div
		apsw_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_pipe[g]),
			.in_item  (item_pipe[g]),
			.out_vld  (vld_pipe[g+1]),
			.out_item (item_pipe[g+1])
		);
	end

	// pick quotient or bypass value per lane
	always_comb begin
		last = item_pipe[apsw_pkg::DIV_STAGES];
		for (int i = 0; i < apsw_pkg::NUM_LANES; i++) begin
			res[i] = last.lane[i].use_div ? last.lane[i].dv.quo : last.lane[i].byp;
		end
	end

	assign done       = vld_pipe[apsw_pkg::DIV_STAGES];
	assign out_chan_0 = res[0];
	assign out_chan_1 = res[1];
	assign out_chan_2 = res[2];
	assign out_alpha  = last.alpha;
	assign clamped    = last.lane[0].clamp || last.lane[1].clamp || last.lane[2].clamp;

`ifndef NO_ASSERTIONS
	// every result comes from an earlier matching start
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result without a matching start");

	// saturation only happens for alpha strictly between 0 and 255
	a_clamp_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |-> (out_alpha != apsw_pkg::ALPHA_ZERO &&
			out_alpha != apsw_pkg::ALPHA_OPAQUE))
		else $error("clamp flagged outside unpremultiply range");

	// a saturated item shows at least one channel at full scale
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |-> (out_chan_0 == apsw_pkg::CHAN_MAX ||
			out_chan_1 == apsw_pkg::CHAN_MAX || out_chan_2 == apsw_pkg::CHAN_MAX))
		else $error("clamp flagged without a saturated channel");
`endif

endmodule

// ===== sv/apsw_front.sv =====
// ----------------------------------------------------------------------------
// apsw_front: swizzle, mode decode and products (stage 1), then saturation
// check, premultiply rounding and division setup (stage 2)
// ----------------------------------------------------------------------------
module apsw_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_0,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_1,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_chan_2,
	input  logic [apsw_pkg::CHAN_W-1:0]  in_alpha,
	input  logic                         direction,
	input  logic                         alpha_mode,
	output logic                         out_vld,
	output apsw_pkg::apsw_item_t         out_item
);

	logic                        vld_s1;
	logic [apsw_pkg::CHAN_W-1:0] chan_s1 [apsw_pkg::NUM_LANES];
	logic [apsw_pkg::PROD_W-1:0] prod_s1 [apsw_pkg::NUM_LANES];
	logic [apsw_pkg::CHAN_W-1:0] alpha_s1;
	logic                        div_en_s1;
	logic                        pre_en_s1;

	logic [apsw_pkg::CHAN_W-1:0] swz [apsw_pkg::NUM_LANES];
	logic                        div_en;
	logic                        pre_en;

	logic                        vld_s2;
	apsw_pkg::apsw_item_t        item_s2;
	apsw_pkg::apsw_item_t        item_nx;

	// swap channels 0 and 2, decode which conversion applies
	always_comb begin
		swz[0] = in_chan_2;
		swz[1] = in_chan_1;
		swz[2] = in_chan_0;
		div_en = (alpha_mode == apsw_pkg::MODE_UNMULT)
			&& (direction == apsw_pkg::DIR_READ_OUT)
			&& (in_alpha != apsw_pkg::ALPHA_ZERO) && (in_alpha != apsw_pkg::ALPHA_OPAQUE);
		pre_en = (alpha_mode == apsw_pkg::MODE_UNMULT)
			&& (direction == apsw_pkg::DIR_WRITE_IN)
			&& (in_alpha != apsw_pkg::ALPHA_OPAQUE);
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// stage 1 payload: biased products for premultiply
	always_ff @(posedge clk) begin
		alpha_s1  <= in_alpha;
		div_en_s1 <= div_en;
		pre_en_s1 <= pre_en;
		for (int i = 0; i < apsw_pkg::NUM_LANES; i++) begin
			chan_s1[i] <= swz[i];
			prod_s1[i] <= swz[i] * in_alpha + apsw_pkg::PREMUL_BIAS;
		end
	end

	// saturation check, divide-by-255 of the product, division setup
	always_comb begin
		logic [apsw_pkg::PROD_W-1:0] num;
		logic [apsw_pkg::PROD_W-1:0] lim;
		logic [apsw_pkg::PROD_W-1:0] rnd;
		logic                        sat;
		item_nx.alpha = alpha_s1;
		for (int i = 0; i < apsw_pkg::NUM_LANES; i++) begin
			num = {chan_s1[i], {apsw_pkg::CHAN_W{1'b0}}}
				- {{apsw_pkg::CHAN_W{1'b0}}, chan_s1[i]};
			lim = {alpha_s1, {apsw_pkg::CHAN_W{1'b0}}};
			sat = div_en_s1 && (num >= lim);
			// x/255 = (x + 1 + (x >> 8)) >> 8 for x below 2^16 - 1
			rnd = prod_s1[i]
				+ {{apsw_pkg::CHAN_W{1'b0}},
					prod_s1[i][apsw_pkg::PROD_W-1 -: apsw_pkg::CHAN_W]}
				+ {{(apsw_pkg::PROD_W-1){1'b0}}, 1'b1};
			item_nx.lane[i].clamp   = sat;
			item_nx.lane[i].use_div = div_en_s1 && !sat;
			if (sat) begin
				item_nx.lane[i].byp = apsw_pkg::CHAN_MAX;
			end else if (pre_en_s1) begin
				item_nx.lane[i].byp = rnd[apsw_pkg::PROD_W-1 -: apsw_pkg::CHAN_W];
			end else begin
				item_nx.lane[i].byp = chan_s1[i];
			end
			item_nx.lane[i].dv.rem = num[apsw_pkg::PROD_W-1 -: apsw_pkg::CHAN_W];
			item_nx.lane[i].dv.lo  = num[apsw_pkg::CHAN_W-1:0];
			item_nx.lane[i].dv.quo = '0;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		item_s2 <= item_nx;
	end

	assign out_vld  = vld_s2;
	assign out_item = item_s2;

endmodule

// ===== sv/apsw_div_stage.sv =====
// ----------------------------------------------------------------------------
// apsw_div_stage: one pipeline stage of the restoring divider
// Resolves two quotient bits of c*255/alpha in each of the three lanes.
// ----------------------------------------------------------------------------
module apsw_div_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  apsw_pkg::apsw_item_t  in_item,
	output logic                  out_vld,
	output apsw_pkg::apsw_item_t  out_item
);

	logic                 vld_s1;
	apsw_pkg::apsw_item_t item_s1;
	apsw_pkg::apsw_item_t item_nx;

	// shift in two dividend bits per lane, one quotient bit each
	always_comb begin
		logic [apsw_pkg::CHAN_W:0] st;
		item_nx = in_item;
		for (int i = 0; i < apsw_pkg::NUM_LANES; i++) begin
			for (int k = 0; k < apsw_pkg::DIV_BITS_PER_STAGE; k++) begin
				st = apsw_pkg::div_step(item_nx.lane[i].dv.rem,
					item_nx.lane[i].dv.lo[apsw_pkg::CHAN_W-1], in_item.alpha);
				item_nx.lane[i].dv.rem = st[apsw_pkg::CHAN_W-1:0];
				item_nx.lane[i].dv.lo  = {item_nx.lane[i].dv.lo[apsw_pkg::CHAN_W-2:0], 1'b0};
				item_nx.lane[i].dv.quo = {item_nx.lane[i].dv.quo[apsw_pkg::CHAN_W-2:0],
					st[apsw_pkg::CHAN_W]};
			end
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// hold payload
	always_ff @(posedge clk) begin
		item_s1 <= item_nx;
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for pixel_alpha_premultiply_swizzle_unit
// Drives pixels through the command port under every direction and alpha
// mode, predicts each converted pixel in a scoreboard class and compares
// every strobed result field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LATENCY   = 6;
	localparam int unsigned PHASE_LEN = 250;

	typedef logic [apsw_pkg::CHAN_W-1:0] chan_t;

	typedef struct {
		chan_t c0;
		chan_t c1;
		chan_t c2;
		chan_t alpha;
	} pixel_in_t;

	typedef struct {
		chan_t o0;
		chan_t o1;
		chan_t o2;
		chan_t alpha;
		logic  clamped;
	} pixel_out_t;

	// expected converted pixels, held in acceptance order
	class pixel_scoreboard;
		pixel_out_t  converted_q[$];
		logic        dir;
		logic        mode;
		int unsigned fail_count;

		function new();
			dir        = apsw_pkg::DIR_READ_OUT;
			mode       = apsw_pkg::MODE_PREMULT;
			fail_count = 0;
		endfunction

		function void set_reg(logic idx, logic val);
			if (idx == apsw_pkg::REG_DIRECTION) begin
				dir = val;
			end else begin
				mode = val;
			end
		endfunction

		function int unsigned pending();
			return converted_q.size();
		endfunction

		// divide out alpha, saturate above the channel maximum
		function chan_t unmul_chan(chan_t c, chan_t a, inout logic sat);
			int unsigned q;
			q = (int'(c) * int'(apsw_pkg::CHAN_MAX)) / int'(a);
			if (q > int'(apsw_pkg::CHAN_MAX)) begin
				sat = 1'b1;
				q   = int'(apsw_pkg::CHAN_MAX);
			end
			return chan_t'(q);
		endfunction

		// multiply in alpha, rounding up with the bias
		function chan_t premul_chan(chan_t c, chan_t a);
			int unsigned p;
			p = (int'(c) * int'(a) + int'(apsw_pkg::PREMUL_BIAS))
				/ int'(apsw_pkg::CHAN_MAX);
			return chan_t'(p);
		endfunction

		// note an accepted pixel and queue its converted form
		function void note_pixel(pixel_in_t px);
			pixel_out_t r;
			r.o0      = px.c2;
			r.o1      = px.c1;
			r.o2      = px.c0;
			r.alpha   = px.alpha;
			r.clamped = 1'b0;
			if (mode == apsw_pkg::MODE_UNMULT) begin
				if (dir == apsw_pkg::DIR_READ_OUT) begin
					if (px.alpha != apsw_pkg::ALPHA_ZERO
						&& px.alpha != apsw_pkg::ALPHA_OPAQUE) begin
						r.o0 = unmul_chan(px.c2, px.alpha, r.clamped);
						r.o1 = unmul_chan(px.c1, px.alpha, r.clamped);
						r.o2 = unmul_chan(px.c0, px.alpha, r.clamped);
					end
				end else if (px.alpha != apsw_pkg::ALPHA_OPAQUE) begin
					r.o0 = premul_chan(px.c2, px.alpha);
					r.o1 = premul_chan(px.c1, px.alpha);
					r.o2 = premul_chan(px.c0, px.alpha);
				end
			end
			converted_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s expected %0d actual %0d", name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		// check a strobed result against the oldest expectation
		function void check_pixel(pixel_out_t got);
			pixel_out_t exp_px;
			if (converted_q.size() == 0) begin
				$error("result with no pixel outstanding: %0d %0d %0d %0d",
					got.o0, got.o1, got.o2, got.alpha);
				fail_count++;
				return;
			end
			exp_px = converted_q.pop_front();
			compare_field("out_chan_0", exp_px.o0, got.o0);
			compare_field("out_chan_1", exp_px.o1, got.o1);
			compare_field("out_chan_2", exp_px.o2, got.o2);
			compare_field("out_alpha", exp_px.alpha, got.alpha);
			compare_field("clamped", exp_px.clamped, got.clamped);
		endfunction

		function void check_drained();
			if (converted_q.size() != 0) begin
				$error("%0d pixels never came out", converted_q.size());
				fail_count++;
			end
		endfunction
	endclass

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_we    = 1'b0;
	logic  cfg_idx   = 1'b0;
	logic  cfg_data  = 1'b0;
	logic  start     = 1'b0;
	logic  busy;
	chan_t in_chan_0 = '0;
	chan_t in_chan_1 = '0;
	chan_t in_chan_2 = '0;
	chan_t in_alpha  = '0;
	logic  done;
	chan_t out_chan_0;
	chan_t out_chan_1;
	chan_t out_chan_2;
	chan_t out_alpha;
	logic  clamped;

	pixel_scoreboard sb = new();

	pixel_alpha_premultiply_swizzle_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.in_chan_0  (in_chan_0),
		.in_chan_1  (in_chan_1),
		.in_chan_2  (in_chan_2),
		.in_alpha   (in_alpha),
		.done       (done),
		.out_chan_0 (out_chan_0),
		.out_chan_1 (out_chan_1),
		.out_chan_2 (out_chan_2),
		.out_alpha  (out_alpha),
		.clamped    (clamped)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// note every pixel taken by the block
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_pixel('{in_chan_0, in_chan_1, in_chan_2, in_alpha});
		end
	end

	// check every strobed result
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_pixel('{out_chan_0, out_chan_1, out_chan_2, out_alpha, clamped});
		end
	end

	// hold start low for random gaps, then present one pixel until taken
	task automatic send_pixel(input pixel_in_t px, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		in_chan_0 <= px.c0;
		in_chan_1 <= px.c1;
		in_chan_2 <= px.c2;
		in_alpha  <= px.alpha;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	// stop sending and wait until every queued pixel has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() > 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// write both registers on an idle block
	task automatic configure(input logic dir, input logic mode);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= apsw_pkg::REG_DIRECTION;
		cfg_data <= dir;
		@(posedge clk);
		sb.set_reg(apsw_pkg::REG_DIRECTION, dir);
		cfg_idx  <= apsw_pkg::REG_ALPHA_MODE;
		cfg_data <= mode;
		@(posedge clk);
		sb.set_reg(apsw_pkg::REG_ALPHA_MODE, mode);
		cfg_we   <= 1'b0;
	endtask

	// mostly well-formed premultiplied colors, with alpha edges favored
	function automatic pixel_in_t rand_pixel();
		pixel_in_t px;
		case ($urandom_range(7))
			0: px.alpha = apsw_pkg::ALPHA_ZERO;
			1: px.alpha = apsw_pkg::ALPHA_OPAQUE;
			2: px.alpha = chan_t'($urandom_range(15, 1));
			3: px.alpha = chan_t'($urandom_range(254, 240));
			default: px.alpha = chan_t'($urandom_range(255));
		endcase
		if ($urandom_range(9) < 6) begin
			px.c0 = chan_t'($urandom_range(px.alpha));
			px.c1 = chan_t'($urandom_range(px.alpha));
			px.c2 = chan_t'($urandom_range(px.alpha));
		end else begin
			px.c0 = chan_t'($urandom_range(255));
			px.c1 = chan_t'($urandom_range(255));
			px.c2 = chan_t'($urandom_range(255));
		end
		return px;
	endfunction

	task automatic run_phase(input logic dir, input logic mode, input int unsigned idle_pct);
		configure(dir, mode);
		repeat (PHASE_LEN) send_pixel(rand_pixel(), idle_pct);
	endtask

	initial begin
		int unsigned guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: swizzle only
		send_pixel('{8'd1, 8'd2, 8'd3, 8'd4}, 0);
		send_pixel('{8'd255, 8'd0, 8'd255, 8'd0}, 0);

		// read-out unpremultiply: alpha zero, opaque, overflow, exact fit
		configure(apsw_pkg::DIR_READ_OUT, apsw_pkg::MODE_UNMULT);
		send_pixel('{8'd10, 8'd20, 8'd30, 8'd0}, 0);
		send_pixel('{8'd1, 8'd2, 8'd3, 8'd255}, 0);
		send_pixel('{8'd200, 8'd100, 8'd50, 8'd100}, 0);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd1}, 0);
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd1}, 0);
		send_pixel('{8'd254, 8'd253, 8'd255, 8'd254}, 0);
		send_pixel('{8'd0, 8'd128, 8'd1, 8'd128}, 0);

		// write-in premultiply: opaque, alpha zero, rounding at the edges
		configure(apsw_pkg::DIR_WRITE_IN, apsw_pkg::MODE_UNMULT);
		send_pixel('{8'd7, 8'd8, 8'd9, 8'd255}, 0);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd0}, 0);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd1}, 0);
		send_pixel('{8'd255, 8'd128, 8'd1, 8'd254}, 0);
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd128}, 0);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd254}, 0);

		// write-in swizzle only
		configure(apsw_pkg::DIR_WRITE_IN, apsw_pkg::MODE_PREMULT);
		send_pixel('{8'haa, 8'h55, 8'hff, 8'h00}, 0);
		send_pixel('{8'h55, 8'haa, 8'h00, 8'hff}, 0);

		// random pixels across every setting and idle profile
		run_phase(apsw_pkg::DIR_READ_OUT, apsw_pkg::MODE_UNMULT, 12);
		run_phase(apsw_pkg::DIR_WRITE_IN, apsw_pkg::MODE_PREMULT, 12);
		run_phase(apsw_pkg::DIR_WRITE_IN, apsw_pkg::MODE_UNMULT, 68);
		run_phase(apsw_pkg::DIR_READ_OUT, apsw_pkg::MODE_PREMULT, 68);
		run_phase(apsw_pkg::DIR_READ_OUT, apsw_pkg::MODE_UNMULT, 0);
		run_phase(apsw_pkg::DIR_WRITE_IN, apsw_pkg::MODE_UNMULT, 0);

		// let the pipeline empty, bounded
		start <= 1'b0;
		guard = 0;
		while (sb.pending() > 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		sb.check_drained();
		if (sb.fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// end a hung run
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== pixel_alpha_premultiply_swizzle_unit.f =====
sv/apsw_pkg.sv
sv/apsw_front.sv
sv/apsw_div_stage.sv
sv/pixel_alpha_premultiply_swizzle_unit.sv
verif/tb_top.sv
